// ----- rtl/sacd_pkg.sv -----
// Shared types and constants for the settle and ceiling deferral core.
// Holds the input and result word structs, register indexes and reset values.
// No dependencies.
package sacd_pkg;

    // fixed field widths
    localparam int FIELD_VALUE_W = 64;
    localparam int FIELD_TIME_W  = 16;
    localparam int MULT_W        = 4;
    localparam int CEIL_W        = FIELD_TIME_W + MULT_W;
    localparam int CFG_INDEX_W   = 2;
    localparam int CFG_DATA_W    = 16;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_TIME   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_COST_MULTIPLE = 2'd1;

    // register reset values
    localparam logic [FIELD_TIME_W-1:0] SETTLE_TIME_RESET   = 16'd1440;
    localparam logic [MULT_W-1:0]       COST_MULTIPLE_RESET = 4'd4;

    // input word: one poll
    typedef struct packed {
        logic                     kind;
        logic [FIELD_VALUE_W-1:0] wanted_value;
        logic [FIELD_VALUE_W-1:0] built_value;
        logic                     gesture_held;
        logic [FIELD_TIME_W-1:0]  elapsed_time;
        logic [FIELD_TIME_W-1:0]  rebuild_cost;
    } in_word_t;

    // result word: one decision
    typedef struct packed {
        logic regenerate;
        logic deferring_now;
    } out_word_t;

endpackage

// ----- rtl/settle_and_ceiling_deferral_core.sv -----
// Debounce with a maximum hold time: poll comparison, deferral timers, result.
// An accepted word passes through the input stage register and then the result stage register.
// Throughput: one word per cycle while the output is not stalled; the timer state updates as each word leaves.
// Reset (rst_n, async, active low): timers and deferral clear, registers go
// to settle_time 1440 and cost_multiple 4, both pipeline stages empty.
// Depends on sacd_pkg and sacd_decide.
module settle_and_ceiling_deferral_core
    import sacd_pkg::*;
#(
    parameter int TIME_WIDTH  = 24,
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_word_t               in_word,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_word_t              out_word,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [VALUE_WIDTH-1:0] NEG_ZERO = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    // configuration
    logic [FIELD_TIME_W-1:0] settle_time_reg;
    logic [MULT_W-1:0]       cost_multiple_reg;

    // input stage
    logic                    s1_valid_reg;
    logic                    s1_kind_reg;
    logic [VALUE_WIDTH-1:0]  s1_wanted_reg;
    logic                    s1_match_reg;
    logic                    s1_held_reg;
    logic [FIELD_TIME_W-1:0] s1_elapsed_reg;
    logic [CEIL_W-1:0]       s1_ceiling_reg;

    // deferral state
    logic                    deferring_reg;
    logic [VALUE_WIDTH-1:0]  deferred_value_reg;
    logic [TIME_WIDTH-1:0]   settled_time_reg;
    logic [TIME_WIDTH-1:0]   held_time_reg;
    logic                    deferring_next;
    logic [VALUE_WIDTH-1:0]  deferred_value_next;
    logic [TIME_WIDTH-1:0]   settled_time_next;
    logic [TIME_WIDTH-1:0]   held_time_next;

    // result stage
    logic                    out_valid_reg;
    out_word_t               out_word_reg;
    out_word_t               result;

    logic                    out_free;
    logic                    s1_move;
    logic                    in_take;
    logic [VALUE_WIDTH-1:0]  wanted_raw;
    logic [VALUE_WIDTH-1:0]  built_raw;
    logic [VALUE_WIDTH-1:0]  wanted_norm;
    logic [VALUE_WIDTH-1:0]  built_norm;
    logic [CEIL_W-1:0]       cost_product;
    logic [CEIL_W-1:0]       ceiling;

    // flow control
    assign out_free  = !out_valid_reg || !out_stall;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_stall  = s1_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign cfg_ready = 1'b1;

    // value masking and negative zero on seek polls
    assign wanted_raw  = in_word.wanted_value[VALUE_WIDTH-1:0];
    assign built_raw   = in_word.built_value[VALUE_WIDTH-1:0];
    assign wanted_norm = (in_word.kind && (wanted_raw == NEG_ZERO)) ? '0 : wanted_raw;
    assign built_norm  = (in_word.kind && (built_raw == NEG_ZERO)) ? '0 : built_raw;

    // hold ceiling: max(settle_time, cost * multiple)
    assign cost_product = CEIL_W'(in_word.rebuild_cost) * CEIL_W'(cost_multiple_reg);
    assign ceiling = (cost_product < CEIL_W'(settle_time_reg)) ?
                     CEIL_W'(settle_time_reg) : cost_product;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_time_reg   <= SETTLE_TIME_RESET;
            cost_multiple_reg <= COST_MULTIPLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SETTLE_TIME:   settle_time_reg   <= cfg_data;
                CFG_COST_MULTIPLE: cost_multiple_reg <= cfg_data[MULT_W-1:0];
                default:           ;
            endcase
        end
    end

    // input stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_take)
            s1_valid_reg <= 1'b1;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    // input stage payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_kind_reg    <= in_word.kind;
            s1_wanted_reg  <= wanted_norm;
            s1_match_reg   <= (wanted_norm == built_norm);
            s1_held_reg    <= in_word.gesture_held;
            s1_elapsed_reg <= in_word.elapsed_time;
            s1_ceiling_reg <= ceiling;
        end
    end

    sacd_decide #(
        .TIME_WIDTH  (TIME_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_decide (
        .kind                (s1_kind_reg),
        .wanted              (s1_wanted_reg),
        .match               (s1_match_reg),
        .gesture_held        (s1_held_reg),
        .elapsed             (s1_elapsed_reg),
        .ceiling             (s1_ceiling_reg),
        .settle_time         (settle_time_reg),
        .deferring           (deferring_reg),
        .deferred_value      (deferred_value_reg),
        .settled_time        (settled_time_reg),
        .held_time           (held_time_reg),
        .deferring_next      (deferring_next),
        .deferred_value_next (deferred_value_next),
        .settled_time_next   (settled_time_next),
        .held_time_next      (held_time_next),
        .result              (result)
    );

    // deferral state update as a word leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deferring_reg      <= 1'b0;
            deferred_value_reg <= '0;
            settled_time_reg   <= '0;
            held_time_reg      <= '0;
        end
        else if (s1_move)
        begin
            deferring_reg      <= deferring_next;
            deferred_value_reg <= deferred_value_next;
            settled_time_reg   <= settled_time_next;
            held_time_reg      <= held_time_next;
        end
    end

    // result stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // result stage payload
    always_ff @(posedge clk)
    begin
        if (s1_move)
            out_word_reg <= result;
    end

    // a rebuild always ends the deferral
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_word_reg.regenerate |-> !out_word_reg.deferring_now)
        else $error("rebuild reported while still deferring");

    // the shown flag matches the stored deferral state
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_word_reg.deferring_now == deferring_reg))
        else $error("result flag and deferral state disagree");

    // input stalls only when both stages are full
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with room in the pipeline");

    // a word leaving the input stage shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> out_valid_reg)
        else $error("word lost between stages");

endmodule

// ----- rtl/sacd_decide.sv -----
// Combinational decision step of the deferral core: next timer state and result.
// Depends on sacd_pkg for field widths and the result word type.
module sacd_decide
    import sacd_pkg::*;
#(
    parameter int TIME_WIDTH  = 24,
    parameter int VALUE_WIDTH = 64
)
(
    input  logic                    kind,
    input  logic [VALUE_WIDTH-1:0]  wanted,
    input  logic                    match,
    input  logic                    gesture_held,
    input  logic [FIELD_TIME_W-1:0] elapsed,
    input  logic [CEIL_W-1:0]       ceiling,
    input  logic [FIELD_TIME_W-1:0] settle_time,
    input  logic                    deferring,
    input  logic [VALUE_WIDTH-1:0]  deferred_value,
    input  logic [TIME_WIDTH-1:0]   settled_time,
    input  logic [TIME_WIDTH-1:0]   held_time,
    output logic                    deferring_next,
    output logic [VALUE_WIDTH-1:0]  deferred_value_next,
    output logic [TIME_WIDTH-1:0]   settled_time_next,
    output logic [TIME_WIDTH-1:0]   held_time_next,
    output out_word_t               result
);

    localparam int CMP_W = (TIME_WIDTH > CEIL_W) ? TIME_WIDTH : CEIL_W;

    logic [TIME_WIDTH:0]   held_sum;
    logic [TIME_WIDTH:0]   settled_sum;
    logic [TIME_WIDTH-1:0] held_sat;
    logic [TIME_WIDTH-1:0] settled_sat;
    logic [TIME_WIDTH-1:0] settled_upd;
    logic                  value_moved;
    logic                  fire;

    // saturating timer adds
    assign held_sum    = {1'b0, held_time} + (TIME_WIDTH+1)'(elapsed);
    assign settled_sum = {1'b0, settled_time} + (TIME_WIDTH+1)'(elapsed);
    assign held_sat    = held_sum[TIME_WIDTH] ? '1 : held_sum[TIME_WIDTH-1:0];
    assign settled_sat = settled_sum[TIME_WIDTH] ? '1 : settled_sum[TIME_WIDTH-1:0];

    // settle timer restarts when the wanted value moves
    assign value_moved = (wanted != deferred_value);
    assign settled_upd = value_moved ? '0 : settled_sat;

    // fire once settled, or once the hold ceiling is reached
    assign fire = !((settled_upd < TIME_WIDTH'(settle_time)) &&
                    (CMP_W'(held_sat) < CMP_W'(ceiling)));

    // decision
    always_comb
    begin
        deferring_next      = deferring;
        deferred_value_next = deferred_value;
        settled_time_next   = settled_time;
        held_time_next      = held_time;
        result.regenerate   = 1'b0;
        if (match)
        begin
            deferring_next    = 1'b0;
            settled_time_next = '0;
            held_time_next    = '0;
        end
        else if (kind && !gesture_held)
        begin
            // seek released: rebuild right away
            deferring_next      = 1'b0;
            settled_time_next   = '0;
            held_time_next      = '0;
            deferred_value_next = wanted;
            result.regenerate   = 1'b1;
        end
        else if (!deferring)
        begin
            // first mismatch opens a deferral
            deferring_next      = 1'b1;
            settled_time_next   = '0;
            held_time_next      = '0;
            deferred_value_next = wanted;
        end
        else
        begin
            deferred_value_next = wanted;
            if (fire)
            begin
                deferring_next    = 1'b0;
                settled_time_next = '0;
                held_time_next    = '0;
                result.regenerate = 1'b1;
            end
            else
            begin
                settled_time_next = settled_upd;
                held_time_next    = held_sat;
            end
        end
        result.deferring_now = deferring_next;
    end

endmodule
